>>> sv/bglt_pkg.sv
// Shared types, constants and helpers for the bitmap glyph text layout unit.
`timescale 1ns / 1ps
package bglt_pkg;

    // Screen size used for clipping
    localparam int SCREEN_COLUMNS = 480;
    localparam int SCREEN_ROWS    = 272;

    // Glyph geometry
    localparam int GLYPH_SIZE   = 12;
    localparam int GLYPH_BITS   = GLYPH_SIZE * GLYPH_SIZE;
    localparam int ROW_CNT_W    = $clog2(GLYPH_SIZE);
    localparam logic [ROW_CNT_W-1:0] LAST_ROW_IDX = ROW_CNT_W'(GLYPH_SIZE - 1);

    // Cursor steps
    localparam logic [4:0] LINE_ADVANCE = 5'd13;
    localparam logic [4:0] HALF_ADVANCE = 5'd6;
    localparam logic [4:0] FULL_ADVANCE = 5'd12;

    // Special character codes
    localparam logic [15:0] CODE_END     = 16'd0;
    localparam logic [15:0] CODE_NEWLINE = 16'd10;

    // Half-width code ranges
    localparam logic [15:0] HALF_A_HI = 16'h00FF;
    localparam logic [15:0] HALF_B_LO = 16'hFF61;
    localparam logic [15:0] HALF_B_HI = 16'hFF9F;
    localparam logic [15:0] HALF_C_LO = 16'hFFE8;
    localparam logic [15:0] HALF_C_HI = 16'hFFEE;

    // Configuration register indexes (byte address = 4 * index)
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [1:0] REG_DRAW_COLOR = 2'd2;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One glyph to draw
    typedef struct packed {
        logic signed [15:0]    cursor_x;
        logic signed [15:0]    cursor_y;
        logic [GLYPH_BITS-1:0] rows;
        logic [31:0]           color;
    } t_glyph_job;

    // Push side of the queue
    typedef struct packed {
        logic       valid;
        t_glyph_job job;
    } t_q_push;

    // Queue status
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    // Add a small step to a coordinate, clamping at the top of the range
    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic [4:0] b);
        logic signed [16:0] s;
        s = $signed({a[15], a}) + $signed({12'd0, b});
        return (s > 17'sd32767) ? 16'sh7FFF : s[15:0];
    endfunction

endpackage

>>> sv/bglt_ifaces.sv
// Request channel interfaces: character input and row-write output.
`timescale 1ns / 1ps
interface bglt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic [47:0] glyph_rows_low;
    logic [47:0] glyph_rows_mid;
    logic [47:0] glyph_rows_high;

    modport source (output valid, char_code, glyph_rows_low, glyph_rows_mid,
                    glyph_rows_high, input ready);
    modport sink   (input valid, char_code, glyph_rows_low, glyph_rows_mid,
                    glyph_rows_high, output ready);
endinterface

interface bglt_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] row_x;
    logic signed [15:0] row_y;
    logic [11:0]        write_mask;
    logic [31:0]        pixel_color;
    logic               last_row;

    modport source (output valid, row_x, row_y, write_mask, pixel_color, last_row,
                    input ready);
    modport sink   (input valid, row_x, row_y, write_mask, pixel_color, last_row,
                    output ready);
endinterface

>>> sv/bitmap_glyph_text_layout_unit.sv
// Top level: configuration registers, front end, job queue and row writer.
//
//  channel   dir  handshake               payload
//  i_char    in   valid/ready             char_code, glyph_rows_low/mid/high
//  o_row     out  valid/ready             row_x, row_y, write_mask, pixel_color, last_row
//  apb       in   psel/penable/pwrite     paddr, pwdata -> prdata (pready tied high)
//
// A drawn character gives 12 row writes, one per cycle unless o_row stalls; the row
// writer takes the next queued glyph as it sends the last row of the one before.
// Newline and end-of-string requests only update the cursor state and give no output.
// A two-entry job queue lets characters be taken while rows are stalled.
// Reset is synchronous and active low; the cursor reloads the origin first.
`timescale 1ns / 1ps
module bitmap_glyph_text_layout_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bglt_in_if.sink                       i_char,
    bglt_out_if.source                    o_row,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bglt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bglt_pkg::*;

    logic signed [15:0] r_origin_x, r_origin_y;
    logic [31:0]        r_draw_color;
    logic               w_wr;
    logic [1:0]         w_idx;

    t_q_push            w_push;
    t_q_stat            w_stat;
    t_glyph_job         w_head;
    logic               w_pop;

    // Configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_draw_color <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_ORIGIN_X:   r_origin_x   <= pwdata[15:0];
                REG_ORIGIN_Y:   r_origin_y   <= pwdata[15:0];
                REG_DRAW_COLOR: r_draw_color <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_X:   prdata = {{16{r_origin_x[15]}}, r_origin_x};
            REG_ORIGIN_Y:   prdata = {{16{r_origin_y[15]}}, r_origin_y};
            REG_DRAW_COLOR: prdata = r_draw_color;
            default:        prdata = '0;
        endcase
    end

    bglt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_char),
        .i_origin_x   (r_origin_x),
        .i_origin_y   (r_origin_y),
        .i_draw_color (r_draw_color),
        .i_q_stat     (w_stat),
        .o_q_push     (w_push)
    );

    bglt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    bglt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_stat),
        .o_pop    (w_pop),
        .o_row    (o_row)
    );

`ifndef SYNTHESIS
    // Any written pixel lies on a visible screen row
    a_mask_row_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && o_row.write_mask != 12'd0) |->
        (o_row.row_y >= 16'sd0 && o_row.row_y < 16'(SCREEN_ROWS)))
        else $error("write mask set on an off-screen row");

    // First column written only when it is on screen
    a_mask_col_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && o_row.write_mask[0]) |->
        (o_row.row_x >= 16'sd0 && o_row.row_x < 16'(SCREEN_COLUMNS)))
        else $error("first column written off screen");

    // Queue fill count stays within its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= QCNT_W'(QDEPTH))
        else $error("job queue overfilled");

    // A glyph request is never taken while the queue is full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.full |-> !w_push.valid)
        else $error("glyph pushed into a full queue");
`endif

endmodule

>>> sv/bglt_front.sv
// Front end: accepts characters, tracks the cursor and queues glyph jobs.
`timescale 1ns / 1ps
module bglt_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bglt_in_if.sink                  i_char,
    input  logic signed [15:0]       i_origin_x,
    input  logic signed [15:0]       i_origin_y,
    input  logic [31:0]              i_draw_color,
    input  bglt_pkg::t_q_stat        i_q_stat,
    output bglt_pkg::t_q_push        o_q_push
);
    import bglt_pkg::*;

    logic signed [15:0] r_cursor_x, n_cursor_x;
    logic signed [15:0] r_cursor_y, n_cursor_y;
    logic               r_at_start, n_at_start;
    logic signed [15:0] w_eff_x, w_eff_y;
    logic               w_accept, w_is_end, w_is_nl, w_half;
    logic [15:0]        w_code;

    assign w_code   = i_char.char_code;
    assign w_is_end = (w_code == CODE_END);
    assign w_is_nl  = (w_code == CODE_NEWLINE);
    assign w_half   = (w_code <= HALF_A_HI) ||
                      (w_code >= HALF_B_LO && w_code <= HALF_B_HI) ||
                      (w_code >= HALF_C_LO && w_code <= HALF_C_HI);

    // Stall only when the job queue has no room
    assign i_char.ready = !i_q_stat.full;
    assign w_accept     = i_char.valid && i_char.ready;

    // Cursor as seen by this request (string start reloads the origin)
    assign w_eff_x = r_at_start ? i_origin_x : r_cursor_x;
    assign w_eff_y = r_at_start ? i_origin_y : r_cursor_y;

    // Classify and update the cursor
    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_at_start = r_at_start;
        if (w_accept) begin
            n_at_start = 1'b0;
            n_cursor_x = w_eff_x;
            n_cursor_y = w_eff_y;
            if (w_is_end) begin
                n_at_start = 1'b1;
            end else if (w_is_nl) begin
                n_cursor_x = i_origin_x;
                n_cursor_y = sat_add(w_eff_y, LINE_ADVANCE);
            end else begin
                n_cursor_x = sat_add(w_eff_x, w_half ? HALF_ADVANCE : FULL_ADVANCE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_at_start <= 1'b1;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_at_start <= n_at_start;
        end
    end

    // Glyph job toward the back end
    assign o_q_push.valid        = w_accept && !w_is_end && !w_is_nl;
    assign o_q_push.job.cursor_x = w_eff_x;
    assign o_q_push.job.cursor_y = w_eff_y;
    assign o_q_push.job.rows     = {i_char.glyph_rows_high, i_char.glyph_rows_mid,
                                    i_char.glyph_rows_low};
    assign o_q_push.job.color    = i_draw_color;

endmodule

>>> sv/bglt_queue.sv
// Short job queue between the front end and the row writer.
`timescale 1ns / 1ps
module bglt_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bglt_pkg::t_q_push     i_push,
    input  logic                  i_pop,
    output bglt_pkg::t_glyph_job  o_head,
    output bglt_pkg::t_q_stat     o_stat
);
    import bglt_pkg::*;

    t_glyph_job          r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_do_push, w_do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;
    assign o_head       = r_mem[r_rp];

    assign w_do_push = i_push.valid && !o_stat.full;
    assign w_do_pop  = i_pop && !o_stat.empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/bglt_back.sv
// Back end: walks a glyph's twelve rows, clips them and drives the output register.
`timescale 1ns / 1ps
module bglt_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bglt_pkg::t_glyph_job  i_head,
    input  bglt_pkg::t_q_stat     i_q_stat,
    output logic                  o_pop,
    bglt_out_if.source            o_row
);
    import bglt_pkg::*;

    logic                  r_busy;
    logic [ROW_CNT_W-1:0]  r_row;
    logic signed [15:0]    r_cx, r_cy;
    logic [GLYPH_BITS-1:0] r_rows;
    logic [31:0]           r_color;

    logic                  r_ov;
    logic signed [15:0]    r_ox, r_oy;
    logic [11:0]           r_omask;
    logic [31:0]           r_ocolor;
    logic                  r_olast;

    logic                  w_adv, w_load;
    logic signed [15:0]    w_y;
    logic                  w_row_on;
    logic [11:0]           w_col_on;
    logic signed [16:0]    w_x;

    // Step one row when the output slot frees up
    assign w_adv  = r_busy && (!r_ov || o_row.ready);
    assign w_load = !r_busy || (w_adv && r_row == LAST_ROW_IDX);
    assign o_pop  = w_load && !i_q_stat.empty;

    // Row position and vertical clip
    assign w_y      = sat_add(r_cy, {{(5 - ROW_CNT_W){1'b0}}, r_row});
    assign w_row_on = !w_y[15] && (w_y < 16'(SCREEN_ROWS));

    // Horizontal clip per column
    always_comb begin
        w_col_on = '0;
        w_x      = '0;
        for (int k = 0; k < GLYPH_SIZE; k++) begin
            w_x         = $signed({r_cx[15], r_cx}) + $signed(17'(k));
            w_col_on[k] = !w_x[16] && (w_x[15:0] < 16'(SCREEN_COLUMNS));
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ov  <= 1'b1;
                r_row <= r_row + 1'b1;
            end else if (o_row.ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Job and output payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ox     <= r_cx;
            r_oy     <= w_y;
            r_omask  <= w_row_on ? (r_rows[11:0] & w_col_on) : '0;
            r_ocolor <= r_color;
            r_olast  <= (r_row == LAST_ROW_IDX);
            r_rows   <= r_rows >> GLYPH_SIZE;
        end
        if (o_pop) begin
            r_cx    <= i_head.cursor_x;
            r_cy    <= i_head.cursor_y;
            r_rows  <= i_head.rows;
            r_color <= i_head.color;
        end
    end

    assign o_row.valid       = r_ov;
    assign o_row.row_x       = r_ox;
    assign o_row.row_y       = r_oy;
    assign o_row.write_mask  = r_omask;
    assign o_row.pixel_color = r_ocolor;
    assign o_row.last_row    = r_olast;

endmodule

>>> dv/bitmap_glyph_text_layout_unit_tb.sv
// Self-checking testbench for the bitmap glyph text layout unit.
`timescale 1ns / 1ps
module bitmap_glyph_text_layout_unit_tb;
    import bglt_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    // One expected row write
    typedef struct {
        logic signed [15:0] row_x;
        logic signed [15:0] row_y;
        logic [11:0]        write_mask;
        logic [31:0]        pixel_color;
        logic               last_row;
    } t_row_write;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    bglt_in_if  u_char_if ();
    bglt_out_if u_row_if ();

    bitmap_glyph_text_layout_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (u_char_if.sink),
        .o_row   (u_row_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Layout state as the block should hold it
    int          layout_origin_x = 0;
    int          layout_origin_y = 0;
    logic [31:0] layout_color    = '0;
    int          pen_x           = 0;
    int          pen_y           = 0;
    bit          string_start    = 1'b1;

    t_row_write  pending_rows[$];
    int          n_errors     = 0;
    int          src_gap_pct  = 0;
    int          sink_stall_pct = 0;
    int          stall_left   = 0;
    int          quiet_cycles = 0;

    localparam logic [47:0] ROWS_ONES = {48{1'b1}};

    function automatic int clamp_top(input int v);
        return (v > 32767) ? 32767 : v;
    endfunction

    function automatic bit is_narrow_code(input logic [15:0] code);
        return (code <= HALF_A_HI) ||
               (code >= HALF_B_LO && code <= HALF_B_HI) ||
               (code >= HALF_C_LO && code <= HALF_C_HI);
    endfunction

    // Advance the layout by one character and queue its row writes
    task automatic predict_char(input logic [15:0] code, input logic [143:0] rows);
        t_row_write  w;
        logic [11:0] bits;
        int          y;
        int          x;
        bit          row_on;
        if (string_start) begin
            pen_x        = layout_origin_x;
            pen_y        = layout_origin_y;
            string_start = 1'b0;
        end
        if (code == CODE_END) begin
            string_start = 1'b1;
        end else if (code == CODE_NEWLINE) begin
            pen_x = layout_origin_x;
            pen_y = clamp_top(pen_y + int'(LINE_ADVANCE));
        end else begin
            for (int r = 0; r < GLYPH_SIZE; r++) begin
                bits   = rows[12*r +: 12];
                y      = pen_y + r;
                row_on = (y >= 0) && (y < SCREEN_ROWS);
                w.write_mask = '0;
                for (int k = 0; k < GLYPH_SIZE; k++) begin
                    x = pen_x + k;
                    if (row_on && x >= 0 && x < SCREEN_COLUMNS && bits[k])
                        w.write_mask[k] = 1'b1;
                end
                w.row_x       = 16'(pen_x);
                w.row_y       = 16'(clamp_top(y));
                w.pixel_color = layout_color;
                w.last_row    = (r == GLYPH_SIZE - 1);
                pending_rows.push_back(w);
            end
            pen_x = clamp_top(pen_x + (is_narrow_code(code) ? int'(HALF_ADVANCE)
                                                              : int'(FULL_ADVANCE)));
        end
    endtask

    // Compare one accepted row write with the oldest expectation
    task automatic check_row_write();
        t_row_write want;
        if (pending_rows.size() == 0) begin
            $error("row write with nothing pending: row_x=%0d row_y=%0d mask=%h",
                   u_row_if.row_x, u_row_if.row_y, u_row_if.write_mask);
            n_errors++;
        end else begin
            want = pending_rows.pop_front();
            if (u_row_if.row_x !== want.row_x) begin
                $error("row_x: expected %0d, got %0d", want.row_x, u_row_if.row_x);
                n_errors++;
            end
            if (u_row_if.row_y !== want.row_y) begin
                $error("row_y: expected %0d, got %0d", want.row_y, u_row_if.row_y);
                n_errors++;
            end
            if (u_row_if.write_mask !== want.write_mask) begin
                $error("write_mask: expected %h, got %h", want.write_mask,
                       u_row_if.write_mask);
                n_errors++;
            end
            if (u_row_if.pixel_color !== want.pixel_color) begin
                $error("pixel_color: expected %h, got %h", want.pixel_color,
                       u_row_if.pixel_color);
                n_errors++;
            end
            if (u_row_if.last_row !== want.last_row) begin
                $error("last_row: expected %0d, got %0d", want.last_row,
                       u_row_if.last_row);
                n_errors++;
            end
        end
    endtask

    // Monitor: predict on accepted characters, check accepted rows
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (u_char_if.valid && u_char_if.ready)
                predict_char(u_char_if.char_code, {u_char_if.glyph_rows_high,
                             u_char_if.glyph_rows_mid, u_char_if.glyph_rows_low});
            if (u_row_if.valid && u_row_if.ready)
                check_row_write();
        end
    end

    // Row sink: ready drops in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left       <= stall_left - 1;
            u_row_if.ready   <= 1'b0;
        end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            stall_left       <= $urandom_range(0, 5);
            u_row_if.ready   <= 1'b0;
        end else begin
            u_row_if.ready   <= 1'b1;
        end
    end

    // Watchdog on cycles with no request moving
    always @(posedge i_clk) begin
        if ((u_char_if.valid && u_char_if.ready) || (u_row_if.valid && u_row_if.ready) ||
            psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmap_glyph_text_layout_unit_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register write: setup phase, then access phase, then idle with psel low
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIGIN_X:   layout_origin_x = int'($signed(value[15:0]));
            REG_ORIGIN_Y:   layout_origin_y = int'($signed(value[15:0]));
            REG_DRAW_COLOR: layout_color    = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_layout(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [31:0] color);
        write_reg(REG_ORIGIN_X, {16'd0, ox});
        write_reg(REG_ORIGIN_Y, {16'd0, oy});
        write_reg(REG_DRAW_COLOR, color);
    endtask

    // Send one character request; valid stays high on return
    task automatic send_char(input logic [15:0] code, input logic [47:0] low,
                             input logic [47:0] mid, input logic [47:0] high);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            u_char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        u_char_if.valid           <= 1'b1;
        u_char_if.char_code       <= code;
        u_char_if.glyph_rows_low  <= low;
        u_char_if.glyph_rows_mid  <= mid;
        u_char_if.glyph_rows_high <= high;
        do @(posedge i_clk); while (!u_char_if.ready);
    endtask

    // Stop sending and wait for every pending row write, then let the block settle
    task automatic wait_idle();
        u_char_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_rows();
        logic [63:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ROWS_ONES;
            default: return t[47:0];
        endcase
    endfunction

    function automatic logic [15:0] pick_code();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)       return CODE_NEWLINE;
        else if (p < 13) return CODE_END;
        else if (p < 35) return 16'($urandom_range(1, HALF_A_HI));
        else if (p < 42) return 16'($urandom_range(HALF_B_LO, HALF_B_HI));
        else if (p < 46) return 16'($urandom_range(HALF_C_LO, HALF_C_HI));
        else             return 16'($urandom);
    endfunction

    // Origins mostly near the screen, some at the coordinate extremes
    function automatic logic [15:0] pick_origin(input int span);
        case ($urandom_range(0, 6))
            0:       return 16'($urandom);
            1:       return 16'(32767 - int'($urandom_range(0, 40)));
            2:       return 16'(-32768 + int'($urandom_range(0, 40)));
            3:       return 16'(span - int'($urandom_range(1, 12)));
            4:       return 16'(-int'($urandom_range(1, 12)));
            5:       return 16'($urandom_range(0, 60));
            default: return 16'(int'($urandom_range(0, span + 40)) - 20);
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_char();
        send_char(pick_code(), rand_rows(), rand_rows(), rand_rows());
    endtask

    // Default registers after reset
    task automatic test_reset_state();
        send_char(16'h0041, ROWS_ONES, ROWS_ONES, ROWS_ONES);
        send_char(CODE_END, '0, '0, '0);
        wait_idle();
    endtask

    // Origins and color at the ends of their ranges, cursor saturation
    task automatic test_register_extremes();
        set_layout(16'h8000, 16'h8000, 32'hFFFF_FFFF);
        send_char(16'hFFFF, ROWS_ONES, ROWS_ONES, ROWS_ONES);
        send_char(CODE_NEWLINE, '0, '0, '0);
        send_char(CODE_END, ROWS_ONES, ROWS_ONES, ROWS_ONES);
        wait_idle();
        set_layout(16'h7FFF, 16'h7FFF, 32'h0000_0000);
        send_char(16'h3042, ROWS_ONES, ROWS_ONES, ROWS_ONES);
        send_char(CODE_NEWLINE, '0, '0, '0);
        send_char(16'h0020, ROWS_ONES, ROWS_ONES, ROWS_ONES);
        send_char(CODE_END, '0, '0, '0);
        wait_idle();
    endtask

    // Partial clipping at the right/bottom and left/top screen edges
    task automatic test_screen_edges();
        set_layout(16'(SCREEN_COLUMNS - 6), 16'(SCREEN_ROWS - 7), 32'h1234_5678);
        send_char(16'h0041, ROWS_ONES, ROWS_ONES, ROWS_ONES);
        send_char(CODE_END, '0, '0, '0);
        wait_idle();
        set_layout(16'hFFFA, 16'hFFFA, 32'h8765_4321);
        send_char(16'h4E00, 48'hA5A_5A5_A5A_5A5, ROWS_ONES, 48'h5A5_A5A_5A5_A5A);
        send_char(CODE_END, '0, '0, '0);
        wait_idle();
    endtask

    // Half/full width range boundaries and a mid-string origin change
    task automatic test_code_widths();
        logic [15:0] codes[10];
        codes = '{16'h00FF, 16'h0100, 16'hFF60, HALF_B_LO, HALF_B_HI,
                  16'hFFA0, 16'hFFE7, HALF_C_LO, HALF_C_HI, 16'hFFEF};
        set_layout(16'd0, 16'd100, 32'h00FF_00FF);
        foreach (codes[i])
            send_char(codes[i], ROWS_ONES, rand_rows(), ROWS_ONES);
        wait_idle();
        // newline takes the new column origin, row origin waits for a new string
        write_reg(REG_ORIGIN_X, 32'd200);
        write_reg(REG_ORIGIN_Y, 32'd10);
        send_char(CODE_NEWLINE, '0, '0, '0);
        send_char(16'h0042, ROWS_ONES, ROWS_ONES, ROWS_ONES);
        send_char(CODE_END, '0, '0, '0);
        wait_idle();
    endtask

    // Random strings across several register settings and idling levels
    task automatic test_random_strings();
        for (int phase = 0; phase < 6; phase++) begin
            set_layout(pick_origin(SCREEN_COLUMNS), pick_origin(SCREEN_ROWS), pick_color());
            case (phase)
                0:       begin src_gap_pct = 30; sink_stall_pct = 20; end
                1:       begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                2:       begin src_gap_pct = 10; sink_stall_pct = 40; end
                3:       begin src_gap_pct = 50; sink_stall_pct = 5;  end
                default: begin src_gap_pct = 20; sink_stall_pct = 15; end
            endcase
            for (int n = 0; n < 45; n++) begin
                // sender holds off until the block has drained
                if (phase == 2 && n == 22)
                    wait_idle();
                send_random_char();
            end
            wait_idle();
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_streaming();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        set_layout(pick_origin(SCREEN_COLUMNS), pick_origin(SCREEN_ROWS), pick_color());
        for (int n = 0; n < 60; n++)
            send_random_char();
        wait_idle();
    endtask

    initial begin
        i_rst_n                   <= 1'b0;
        psel                      <= 1'b0;
        penable                   <= 1'b0;
        pwrite                    <= 1'b0;
        paddr                     <= '0;
        pwdata                    <= '0;
        u_char_if.valid           <= 1'b0;
        u_char_if.char_code       <= '0;
        u_char_if.glyph_rows_low  <= '0;
        u_char_if.glyph_rows_mid  <= '0;
        u_char_if.glyph_rows_high <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_gap_pct    = 20;
        sink_stall_pct = 20;
        test_reset_state();
        test_register_extremes();
        test_screen_edges();
        test_code_widths();
        test_random_strings();
        test_streaming();

        if (n_errors == 0)
            $display("bitmap_glyph_text_layout_unit_tb: done, clean");
        else
            $display("bitmap_glyph_text_layout_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/bglt_pkg.sv
sv/bglt_ifaces.sv
sv/bglt_front.sv
sv/bglt_queue.sv
sv/bglt_back.sv
sv/bitmap_glyph_text_layout_unit.sv
dv/bitmap_glyph_text_layout_unit_tb.sv
